// ===== src/line_blob_segmenter_defines.svh =====
// Assertion macros shared by the line blob segmenter RTL.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef LINE_BLOB_SEGMENTER_DEFINES_SVH
`define LINE_BLOB_SEGMENTER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define LBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lbs_pkg.sv =====
// Package for the line blob segmenter: widths, limits, register codes and
// the result record. No dependencies.
package lbs_pkg;

    localparam int MAX_LINE_PIXELS = 4096;
    localparam int POS_W           = 12;
    localparam int SPAN_W          = 13;
    localparam int LEVEL_W         = 8;
    localparam int COUNT_W         = 12;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_IDX_W       = 2;

    localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(MAX_LINE_PIXELS - 1);
    localparam logic [SPAN_W-1:0]  DARK_MAX  = {SPAN_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = LEVEL_W'(128);
    localparam logic [SPAN_W-1:0]  MIN_WIDTH_RST = SPAN_W'(1);
    localparam logic [SPAN_W-1:0]  MERGE_GAP_RST = SPAN_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_THRESHOLD = 2'd0,
        CFG_MIN_BLOB_WIDTH  = 2'd1,
        CFG_MERGE_GAP       = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic               blob_found;
        logic [POS_W-1:0]   start_index;
        logic [SPAN_W-1:0]  end_index;
        logic               line_done;
        logic [COUNT_W-1:0] blobs_in_line;
    } t_result;

endpackage

// ===== src/lbs_ifs.sv =====
// Valid/ready channel interfaces of the line blob segmenter: pixel input,
// result output and register writes. Depends on lbs_pkg.
interface lbs_pixel_if;
    import lbs_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] pixel_level;
    logic               line_end;
    modport source (output valid, output pixel_level, output line_end, input ready);
    modport sink (input valid, input pixel_level, input line_end, output ready);
endinterface

interface lbs_result_if;
    import lbs_pkg::*;
    logic               valid;
    logic               ready;
    logic               blob_found;
    logic [POS_W-1:0]   start_index;
    logic [SPAN_W-1:0]  end_index;
    logic               line_done;
    logic [COUNT_W-1:0] blobs_in_line;
    modport source (output valid, output blob_found, output start_index, output end_index,
                    output line_done, output blobs_in_line, input ready);
    modport sink (input valid, input blob_found, input start_index, input end_index,
                  input line_done, input blobs_in_line, output ready);
endinterface

interface lbs_cfg_if;
    import lbs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/line_blob_segmenter.sv =====
// Top level of the line blob segmenter: per-pixel blob tracking and a
// two-entry result buffer. Depends on lbs_pkg, lbs_ifs and the defines header.
`include "line_blob_segmenter_defines.svh"

// The segmenter takes one gray pixel per clock and reports bright blobs of a
// scan line as (start, exclusive end) pairs. A pixel at or above the threshold
// register opens or extends a blob; dark runs up to merge_gap pixels are
// bridged, a longer one closes the blob one past its last bright pixel, and
// the pixel flagged line_end closes any open blob and reports the line's blob
// count, after which tracking restarts at pixel index 0. Blobs narrower than
// min_blob_width are dropped (a width of 0 behaves as 1). Throughput is one
// pixel per cycle: the whole per-pixel state update is a short chain of
// compares and subtracts on the registered state, done in the cycle the item
// is accepted. Results are registered in the result buffer before they reach
// the output. A two-entry result buffer decouples the sides:
// input ready drops only while both result entries are full, which takes a
// sink stalled over at least two results; any pixel then waits, whether it
// causes a result or not, and ready rises again the cycle after the sink
// takes an item. Registers may be written at any time but must only change
// while the block is idle.
module line_blob_segmenter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lbs_pixel_if.sink      i_pix,
    lbs_result_if.source   o_res,
    lbs_cfg_if.sink        i_cfg
);
    import lbs_pkg::*;

    // Configuration registers
    logic [LEVEL_W-1:0] r_thr;
    logic [SPAN_W-1:0]  r_min_w;
    logic [SPAN_W-1:0]  r_gap;

    // Line tracking state
    logic               r_inside, n_inside;
    logic [POS_W-1:0]   r_open, n_open;
    logic [SPAN_W-1:0]  r_dark, n_dark;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [COUNT_W-1:0] r_count, n_count;

    // Result buffer: head drives the port, skid catches one more item
    logic               r_hv, n_hv;
    logic               r_sv, n_sv;
    t_result            r_head, n_head;
    t_result            r_skid, n_skid;

    logic               accept, pop, push;
    logic               bright, last;
    logic [SPAN_W-1:0]  dark_inc;
    logic               gap_close, inside_after, do_close;
    logic [POS_W-1:0]   open_c;
    logic [SPAN_W-1:0]  dr_c;
    logic [POS_W-1:0]   span;
    logic               clamp;
    logic [SPAN_W-1:0]  end_c;
    logic [SPAN_W-1:0]  width_c;
    logic               rep;
    logic [COUNT_W-1:0] count_after;
    t_result            res;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THRESHOLD_RST;
            r_min_w <= MIN_WIDTH_RST;
            r_gap   <= MERGE_GAP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LEVEL_THRESHOLD: r_thr   <= i_cfg.data[LEVEL_W-1:0];
                CFG_MIN_BLOB_WIDTH:  r_min_w <= i_cfg.data;
                CFG_MERGE_GAP:       r_gap   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Handshakes: accept whenever the skid entry is free
    assign i_pix.ready = !r_sv;
    assign accept      = i_pix.valid && !r_sv;
    assign pop         = r_hv && o_res.ready;

    assign bright   = i_pix.pixel_level >= r_thr;
    assign last     = i_pix.line_end;
    assign dark_inc = (r_dark == DARK_MAX) ? r_dark : r_dark + SPAN_W'(1);

    // A dark pixel inside a blob extends the run; past merge_gap it closes
    assign gap_close    = !bright && r_inside && (dark_inc > r_gap);
    assign inside_after = bright || (r_inside && !gap_close);
    assign do_close     = gap_close || (last && inside_after);

    // Blob being closed: start, and dark pixels trailing its last bright one
    assign open_c = (bright && !r_inside) ? r_pos : r_open;
    assign dr_c   = bright ? '0 : dark_inc;

    // End is one past the last bright pixel, never below start + 1
    assign span    = r_pos - open_c;
    assign clamp   = dr_c > {1'b0, span};
    assign end_c   = clamp ? ({1'b0, open_c} + SPAN_W'(1))
                           : ({1'b0, r_pos} + SPAN_W'(1) - dr_c);
    assign width_c = clamp ? SPAN_W'(1) : ({1'b0, span} + SPAN_W'(1) - dr_c);
    assign rep     = do_close && (width_c >= r_min_w);

    assign count_after = (rep && r_count != COUNT_MAX) ? r_count + COUNT_W'(1) : r_count;

    always_comb begin
        res.blob_found    = rep;
        res.start_index   = rep ? open_c : '0;
        res.end_index     = rep ? end_c : '0;
        res.line_done     = last;
        res.blobs_in_line = last ? count_after : '0;
    end

    assign push = accept && (rep || last);

    // Next tracking state; the last pixel of a line clears everything
    always_comb begin
        n_inside = r_inside;
        n_open   = r_open;
        n_dark   = r_dark;
        n_pos    = r_pos;
        n_count  = r_count;
        if (accept) begin
            if (last) begin
                n_inside = 1'b0;
                n_open   = '0;
                n_dark   = '0;
                n_pos    = '0;
                n_count  = '0;
            end else begin
                n_inside = inside_after;
                n_open   = open_c;
                n_dark   = (bright || !r_inside || gap_close) ? '0 : dark_inc;
                n_pos    = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
                n_count  = count_after;
            end
        end
    end

    // Result buffer update: pop moves skid to head, push fills the free slot
    always_comb begin
        n_hv   = r_hv;
        n_sv   = r_sv;
        n_head = r_head;
        n_skid = r_skid;
        if (pop) begin
            if (r_sv) begin
                n_head = r_skid;
                n_sv   = 1'b0;
            end else begin
                n_hv = 1'b0;
            end
        end
        if (push) begin
            if (!n_hv) begin
                n_head = res;
                n_hv   = 1'b1;
            end else begin
                n_skid = res;
                n_sv   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_open   <= '0;
            r_dark   <= '0;
            r_pos    <= '0;
            r_count  <= '0;
            r_hv     <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            r_inside <= n_inside;
            r_open   <= n_open;
            r_dark   <= n_dark;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_hv     <= n_hv;
            r_sv     <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_res.valid         = r_hv;
    assign o_res.blob_found    = r_head.blob_found;
    assign o_res.start_index   = r_head.start_index;
    assign o_res.end_index     = r_head.end_index;
    assign o_res.line_done     = r_head.line_done;
    assign o_res.blobs_in_line = r_head.blobs_in_line;

    `LBS_ASSERT_NOW(a_skid_behind_head, r_sv, r_hv, "skid entry held without head entry")
    `LBS_ASSERT_NOW(a_dark_only_inside, r_dark != '0, r_inside, "dark run outside a blob")
    `LBS_ASSERT_NOW(a_blob_end_after_start, r_hv && r_head.blob_found,
        {1'b0, r_head.start_index} < r_head.end_index, "blob end not past start")
    `LBS_ASSERT_NEXT(a_line_end_clears, accept && last,
        r_pos == '0 && !r_inside && r_count == '0, "line state not cleared")

endmodule
